// ===== sv/sdcb_pkg.sv =====
`timescale 1ns / 1ps
package sdcb_pkg;

  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_SNAP = 2'd2;

  localparam logic [1:0] CFG_SMOOTH_TIME  = 2'd0;
  localparam logic [1:0] CFG_MAX_SPEED    = 2'd1;
  localparam logic [1:0] CFG_SETTLE_LIMIT = 2'd2;

  localparam logic [15:0] SMOOTH_TIME_RST  = 16'd6554;
  localparam logic [30:0] MAX_SPEED_RST    = 31'h7FFF_FFFF;
  localparam logic [15:0] SETTLE_LIMIT_RST = 16'd66;
  localparam logic [15:0] ST_MIN           = 16'd66;
  localparam logic [30:0] SPEED_UNLIMITED  = 31'h7FFF_FFFF;

  localparam logic [63:0] K048    = 64'd31457;
  localparam logic [63:0] K0235   = 64'd15401;
  localparam logic [63:0] SAT_LIM = 64'h0000_8000_0000_0000;
  localparam logic [63:0] ONE_Q16 = 64'd65536;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         channel;
    logic signed [31:0] value_in;
    logic [15:0]        tick_length;
  } sdcb_in_t;

  typedef struct packed {
    logic [3:0]         channel_out;
    logic signed [31:0] current_out;
    logic               channel_settled;
    logic               all_settled;
    logic               last;
  } sdcb_out_t;

  function automatic logic signed [31:0] reset_value(input int unsigned idx);
    logic signed [31:0] v;
    v = 32'sd0;
    if (idx inside {0, 1, 2, 9, 10, 11}) begin
      v = 32'sd65536;
    end
    return v;
  endfunction

endpackage

// ===== sv/sdcb_mul.sv =====
`timescale 1ns / 1ps
module sdcb_mul
  import sdcb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic         done,
  output logic [127:0] prod
);

  logic [63:0]  a_q;
  logic [63:0]  b_q;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic [15:0]  digit;
  logic [79:0]  pp;
  logic [127:0] pp_sh;

  always_comb begin
    digit = b_q[{cnt, 4'b0000} +: 16];
    pp    = 80'(a_q) * 80'(digit);
    pp_sh = 128'(pp) << {cnt, 4'b0000};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q  <= a;
        b_q  <= b;
        acc  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + pp_sh;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// ===== sv/sdcb_div.sv =====
`timescale 1ns / 1ps
module sdcb_div
  import sdcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic [64:0] rem;
  logic [63:0] quot;
  logic [63:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] sh;
  logic        fits;

  always_comb begin
    sh   = {rem[63:0], quot[63]};
    fits = sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? (sh - {1'b0, dvs}) : sh;
        quot <= {quot[62:0], fits};
        cnt  <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quot;

endmodule

// ===== sv/smooth_damp_channel_bank.sv =====
`timescale 1ns / 1ps
// Set-target and snap requests: channel read, then written back; results none.
// Tick request: three divisions and five multiplies set up, then five more multiplies per
// channel, none for a settled channel; a held output stalls the run.
// Results stream out in channel order as each channel finishes; one request in flight at a time.
// Reset: registers to defaults, every channel reads its default value through per-entry valid
// bits, so the bank takes requests as soon as reset is released.
module smooth_damp_channel_bank
  import sdcb_pkg::*;
#(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sdcb_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sdcb_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef struct packed {
    logic signed [31:0] cur;
    logic signed [31:0] tgt;
    logic signed [31:0] vel;
  } word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SET_RD, S_SET_WR, S_DIV_OM, S_DIV_X, S_MUL_X2, S_MUL_X3A, S_MUL_X3B,
    S_MUL_DA, S_MUL_DB, S_DIV_E, S_CH_RD, S_CH_LOAD, S_M1, S_M2, S_M3, S_M4, S_M5, S_EMIT
  } state_t;

  state_t state;

  logic [15:0] smooth_time;
  logic [30:0] max_speed;
  logic [15:0] settle_limit;

  word_t       mem [CHANNELS];
  word_t       rd_q;
  logic        rdv_q;
  logic [CHANNELS-1:0] valid;
  logic        mem_we;
  word_t       mem_wdata;
  word_t       ld;

  logic [AW-1:0] ch;
  logic [1:0]    kind;
  logic signed [31:0] val;
  logic [15:0] st;
  logic [15:0] dt;
  logic signed [63:0] md;
  logic        limited;
  logic [63:0] omega, x, x2, x3t, den, e;
  logic signed [31:0] cur, tgt, vel;
  logic signed [63:0] delta, temp, vn;
  logic signed [31:0] newcur, newvel;
  logic        all_acc;

  logic         mul_start, mul_done, mul_neg;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_prod;
  logic         div_start, div_done;
  logic [63:0]  div_n, div_d, div_q;

  logic [15:0] st_eff;
  logic [46:0] md_prod;
  logic signed [63:0] mq16, mq32;
  logic signed [63:0] d_raw, d_clamp, res_raw, op_v;
  logic        pre_settled, post_settled, out_free, is_last;
  logic signed [63:0] lim64, dpre, dpost;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] mulq_fin(input logic [127:0] p, input logic s32,
                                                   input logic neg);
    logic [63:0] mag;
    if (|p[127:64]) begin
      mag = SAT_LIM;
    end else if (s32) begin
      mag = {32'd0, p[63:32]};
    end else begin
      mag = {16'd0, p[63:16]};
    end
    if (mag > SAT_LIM) begin
      mag = SAT_LIM;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  sdcb_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  sdcb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    st_eff  = (smooth_time < ST_MIN) ? ST_MIN : smooth_time;
    md_prod = 47'(max_speed) * 47'(st_eff);
    mq16    = mulq_fin(mul_prod, 1'b0, mul_neg);
    mq32    = mulq_fin(mul_prod, 1'b1, mul_neg);
    ld.cur  = rdv_q ? rd_q.cur : reset_value(32'(ch));
    ld.tgt  = rdv_q ? rd_q.tgt : reset_value(32'(ch));
    ld.vel  = rdv_q ? rd_q.vel : 32'sd0;
    lim64   = $signed(64'(settle_limit));
    dpre    = 64'(ld.cur) - 64'(ld.tgt);
    pre_settled = ($signed(mag64(dpre)) < lim64) &&
                  ($signed(mag64(64'(ld.vel))) < lim64);
    d_raw   = dpre;
    d_clamp = d_raw;
    if (limited) begin
      if (d_raw > md) begin
        d_clamp = md;
      end
      if (d_raw < -md) begin
        d_clamp = -md;
      end
    end
    res_raw = 64'(cur) - delta + mq32;
    dpost   = 64'(newcur) - 64'(tgt);
    post_settled = ($signed(mag64(dpost)) < lim64) &&
                   ($signed(mag64(64'(newvel))) < lim64);
    out_free = !out_valid || out_ready;
    is_last  = (ch == AW'(CHANNELS - 1));
    op_v     = 64'(vel) + mq16;
    mem_we   = 1'b0;
    mem_wdata.cur = newcur;
    mem_wdata.tgt = tgt;
    mem_wdata.vel = newvel;
    if (state == S_SET_WR) begin
      mem_we = 1'b1;
      mem_wdata.tgt = val;
      if (kind == KIND_SNAP) begin
        mem_wdata.cur = val;
        mem_wdata.vel = 32'sd0;
      end else begin
        mem_wdata.cur = ld.cur;
        mem_wdata.vel = ld.vel;
      end
    end else if (state == S_EMIT && out_free) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ch] <= mem_wdata;
    end
    rd_q  <= mem[ch];
    rdv_q <= valid[ch];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[ch] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_time  <= SMOOTH_TIME_RST;
      max_speed    <= MAX_SPEED_RST;
      settle_limit <= SETTLE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SMOOTH_TIME:  smooth_time  <= cfg_data[15:0];
        CFG_MAX_SPEED:    max_speed    <= cfg_data[30:0];
        CFG_SETTLE_LIMIT: settle_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      ch        <= '0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind <= in_data.kind;
            val  <= in_data.value_in;
            if (in_data.kind == KIND_TICK) begin
              st        <= st_eff;
              dt        <= in_data.tick_length;
              md        <= $signed(64'(md_prod[46:16]));
              limited   <= (max_speed != SPEED_UNLIMITED);
              all_acc   <= 1'b1;
              div_n     <= 64'd1 << 33;
              div_d     <= 64'(st_eff);
              div_start <= 1'b1;
              state     <= S_DIV_OM;
            end else if ((in_data.kind == KIND_SET || in_data.kind == KIND_SNAP) &&
                         (32'(in_data.channel) < 32'(CHANNELS))) begin
              ch    <= AW'(in_data.channel);
              state <= S_SET_RD;
            end
          end
        end
        S_SET_RD: state <= S_SET_WR;
        S_SET_WR: state <= S_IDLE;
        S_DIV_OM: begin
          if (div_done) begin
            omega     <= div_q;
            div_n     <= 64'(dt) << 17;
            div_d     <= 64'(st);
            div_start <= 1'b1;
            state     <= S_DIV_X;
          end
        end
        S_DIV_X: begin
          if (div_done) begin
            x         <= div_q;
            mul_a     <= div_q;
            mul_b     <= div_q;
            mul_start <= 1'b1;
            state     <= S_MUL_X2;
          end
        end
        S_MUL_X2: begin
          if (mul_done) begin
            x2        <= mul_prod[63:0] >> 16;
            mul_a     <= mul_prod[63:0] >> 16;
            mul_b     <= x >> 16;
            mul_start <= 1'b1;
            state     <= S_MUL_X3A;
          end
        end
        S_MUL_X3A: begin
          if (mul_done) begin
            x3t       <= mul_prod[63:0];
            mul_a     <= x2;
            mul_b     <= {48'd0, x[15:0]};
            mul_start <= 1'b1;
            state     <= S_MUL_X3B;
          end
        end
        S_MUL_X3B: begin
          if (mul_done) begin
            x3t       <= x3t + (mul_prod[63:0] >> 16);
            mul_a     <= x2;
            mul_b     <= K048;
            mul_start <= 1'b1;
            state     <= S_MUL_DA;
          end
        end
        S_MUL_DA: begin
          if (mul_done) begin
            den       <= ONE_Q16 + x + (mul_prod[63:0] >> 16);
            mul_a     <= x3t;
            mul_b     <= K0235;
            mul_start <= 1'b1;
            state     <= S_MUL_DB;
          end
        end
        S_MUL_DB: begin
          if (mul_done) begin
            div_n     <= 64'd1 << 48;
            div_d     <= den + (mul_prod[63:0] >> 16);
            div_start <= 1'b1;
            state     <= S_DIV_E;
          end
        end
        S_DIV_E: begin
          if (div_done) begin
            e     <= div_q;
            ch    <= '0;
            state <= S_CH_RD;
          end
        end
        S_CH_RD: state <= S_CH_LOAD;
        S_CH_LOAD: begin
          cur <= ld.cur;
          tgt <= ld.tgt;
          vel <= ld.vel;
          if (pre_settled) begin
            newcur <= ld.tgt;
            newvel <= 32'sd0;
            state  <= S_EMIT;
          end else begin
            delta     <= d_clamp;
            mul_a     <= omega;
            mul_b     <= mag64(d_clamp);
            mul_neg   <= d_clamp[63];
            mul_start <= 1'b1;
            state     <= S_M1;
          end
        end
        S_M1: begin
          if (mul_done) begin
            mul_a     <= mag64(op_v);
            mul_b     <= 64'(dt);
            mul_neg   <= op_v[63];
            mul_start <= 1'b1;
            state     <= S_M2;
          end
        end
        S_M2: begin
          if (mul_done) begin
            temp      <= mq16;
            mul_a     <= omega;
            mul_b     <= mag64(mq16);
            mul_neg   <= mq16[63];
            mul_start <= 1'b1;
            state     <= S_M3;
          end
        end
        S_M3: begin
          if (mul_done) begin
            mul_a     <= mag64(64'(vel) - mq16);
            mul_b     <= e;
            mul_neg   <= (64'(vel) - mq16) < 0;
            mul_start <= 1'b1;
            state     <= S_M4;
          end
        end
        S_M4: begin
          if (mul_done) begin
            vn        <= mq32;
            mul_a     <= mag64(delta + temp);
            mul_b     <= e;
            mul_neg   <= (delta + temp) < 0;
            mul_start <= 1'b1;
            state     <= S_M5;
          end
        end
        S_M5: begin
          if (mul_done) begin
            if ((64'(tgt) - 64'(cur) > 0) == (res_raw > 64'(tgt))) begin
              newcur <= tgt;
              newvel <= 32'sd0;
            end else begin
              newcur <= sat32(res_raw);
              newvel <= sat32(vn);
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_data.channel_out     <= 4'(ch);
            out_data.current_out     <= newcur;
            out_data.channel_settled <= post_settled;
            out_data.all_settled     <= is_last && all_acc && post_settled;
            out_data.last            <= is_last;
            all_acc                  <= all_acc && post_settled;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              ch    <= ch + AW'(1);
              state <= S_CH_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tick_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.kind == KIND_TICK) |=> !in_ready)
    else $error("input taken during tick run");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_all_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> !out_data.all_settled)
    else $error("all_settled on non-last result");

  a_emit_holds_mem: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !out_free) |-> !mem_we)
    else $error("channel written back while result stalled");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import sdcb_pkg::*;

  localparam int NCH = 16;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int WATCH_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam int SETTLE_WAIT = 100;

  typedef struct {
    sdcb_in_t           req;
    bit                 typed;
    logic signed [31:0] ch0_value;
    bit                 all_still;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  sdcb_in_t    in_data;
  logic        out_valid;
  logic        out_ready;
  sdcb_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  logic signed [31:0] cur_v [NCH];
  logic signed [31:0] tgt_v [NCH];
  logic signed [31:0] vel_v [NCH];
  logic [15:0]        st_reg;
  logic [30:0]        speed_reg;
  logic [15:0]        eps_reg;

  sdcb_out_t  pending_results[$];
  dir_row_t   dir_rows[$];
  int         errors;
  int         watch_cnt;
  bit         calm;
  bit         hold_req;

  smooth_damp_channel_bank #(.CHANNELS(NCH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint scaled_mul(longint a, longint b, int s);
    logic       neg;
    logic [63:0] ma, mb, mag;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb};
    if (p[127:64] != 0) mag = SAT_LIM;
    else mag = p[63:0] >> s;
    if (mag > SAT_LIM) mag = SAT_LIM;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic bit is_still(int i);
    longint d, v, e;
    d = longint'(cur_v[i]) - longint'(tgt_v[i]);
    v = longint'(vel_v[i]);
    e = longint'({48'd0, eps_reg});
    if (d < 0) d = -d;
    if (v < 0) v = -v;
    return (d < e) && (v < e);
  endfunction

  function automatic void spring_step(int i, longint unsigned dt);
    longint unsigned st, x, x2, x3, den;
    longint omega, ef, cur, tgt, vel, delta, md, aim, tmp, vn, res;
    st = (st_reg < ST_MIN) ? 64'(ST_MIN) : 64'(st_reg);
    omega = longint'((64'd1 << 33) / st);
    x = (dt << 17) / st;
    x2 = (x * x) >> 16;
    x3 = x2 * (x >> 16) + ((x2 * (x & 64'hFFFF)) >> 16);
    den = 64'd65536 + x + ((x2 * K048) >> 16) + ((x3 * K0235) >> 16);
    ef = longint'((64'd1 << 48) / den);
    cur = cur_v[i];
    tgt = tgt_v[i];
    vel = vel_v[i];
    delta = cur - tgt;
    if (speed_reg != SPEED_UNLIMITED) begin
      md = longint'((64'(speed_reg) * st) >> 16);
      if (delta > md) delta = md;
      if (delta < -md) delta = -md;
    end
    aim = cur - delta;
    tmp = scaled_mul(vel + scaled_mul(omega, delta, 16), longint'(dt), 16);
    vn = scaled_mul(vel - scaled_mul(omega, tmp, 16), ef, 32);
    res = aim + scaled_mul(delta + tmp, ef, 32);
    if ((tgt - cur > 0) == (res > tgt)) begin
      res = tgt;
      vn = 0;
    end
    cur_v[i] = clip32(res);
    vel_v[i] = clip32(vn);
  endfunction

  function automatic void predict_request(sdcb_in_t r);
    bit        all;
    sdcb_out_t o;
    if (r.kind == KIND_SET || r.kind == KIND_SNAP) begin
      tgt_v[r.channel] = r.value_in;
      if (r.kind == KIND_SNAP) begin
        cur_v[r.channel] = r.value_in;
        vel_v[r.channel] = '0;
      end
      return;
    end
    if (r.kind != KIND_TICK) return;
    for (int i = 0; i < NCH; i++) begin
      if (is_still(i)) begin
        cur_v[i] = tgt_v[i];
        vel_v[i] = '0;
      end else begin
        spring_step(i, 64'(r.tick_length));
      end
    end
    all = 1'b1;
    for (int i = 0; i < NCH; i++) if (!is_still(i)) all = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      o.channel_out = i[3:0];
      o.current_out = cur_v[i];
      o.channel_settled = is_still(i);
      o.last = (i == NCH - 1);
      o.all_settled = o.last && all;
      pending_results.push_back(o);
    end
  endfunction

  task automatic send_request(sdcb_in_t r);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(r);
  endtask

  task automatic pause_sender();
    int n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SMOOTH_TIME: st_reg = val[15:0];
      CFG_MAX_SPEED: speed_reg = val[30:0];
      CFG_SETTLE_LIMIT: eps_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  function automatic sdcb_in_t mk(logic [1:0] k, logic [3:0] ch, logic [31:0] v,
                                  logic [15:0] dt);
    sdcb_in_t r;
    r.kind = k;
    r.channel = ch;
    r.value_in = v;
    r.tick_length = dt;
    return r;
  endfunction

  function automatic void add_row(sdcb_in_t r, bit typed = 1'b0,
                                  logic signed [31:0] c0 = 32'sd0, bit all = 1'b0);
    dir_row_t d;
    d.req = r;
    d.typed = typed;
    d.ch0_value = c0;
    d.all_still = all;
    dir_rows.push_back(d);
  endfunction

  function automatic sdcb_in_t random_request();
    int          pick;
    logic [31:0] v;
    logic [15:0] dt;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) v = $urandom;
    else v = 32'($signed($urandom_range(0, 2000)) - 1000) <<< $urandom_range(8, 16);
    if ($urandom_range(0, 4) == 0) dt = 16'($urandom);
    else dt = 16'($urandom_range(0, 4000));
    if (pick < 40) return mk(KIND_TICK, 4'($urandom), v, dt);
    if (pick < 70) return mk(KIND_SET, 4'($urandom), v, dt);
    if (pick < 95) return mk(KIND_SNAP, 4'($urandom), v, dt);
    return mk(KIND_NONE, 4'($urandom), v, dt);
  endfunction

  // result checker and receiver stalls
  initial begin
    int        stall;
    sdcb_out_t e;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          e = pending_results.pop_front();
          if (out_data.channel_out !== e.channel_out ||
              out_data.current_out !== e.current_out ||
              out_data.channel_settled !== e.channel_settled ||
              out_data.all_settled !== e.all_settled ||
              out_data.last !== e.last) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on progress
  initial begin
    watch_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        watch_cnt = 0;
      else
        watch_cnt++;
      if (watch_cnt >= WATCH_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int base;
    errors = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1'b1;
    for (int i = 0; i < NCH; i++) begin
      cur_v[i] = reset_value(i);
      tgt_v[i] = reset_value(i);
      vel_v[i] = '0;
    end
    st_reg = SMOOTH_TIME_RST;
    speed_reg = MAX_SPEED_RST;
    eps_reg = SETTLE_LIMIT_RST;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'd1000), 1'b1, 32'sd65536, 1'b1);
    add_row(mk(KIND_SNAP, 4'd0, 32'h7FFF_FFFF, 16'd0));
    add_row(mk(KIND_TICK, 4'd15, 32'hFFFF_FFFF, 16'd1000), 1'b1, 32'sh7FFF_FFFF, 1'b1);
    add_row(mk(KIND_SNAP, 4'd3, 32'h8000_0000, 16'hFFFF));
    add_row(mk(KIND_SET, 4'd3, 32'h7FFF_FFFF, 16'd0));
    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'hFFFF));
    add_row(mk(KIND_SET, 4'd5, -32'sd6553600, 16'd0));
    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'd0));
    add_row(mk(KIND_NONE, 4'd9, 32'h1234_5678, 16'hFFFF));
    add_row(mk(KIND_SET, 4'd15, 32'h5555_5555, 16'h5555));
    add_row(mk(KIND_SNAP, 4'd7, 32'hAAAA_AAAA, 16'hAAAA));
    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'd1));
    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'hFFFF));
    add_row(mk(KIND_SET, 4'd0, 32'sd0, 16'd0));
    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'd3000));
    add_row(mk(KIND_SNAP, 4'd3, 32'sd0, 16'd0));
    add_row(mk(KIND_SET, 4'd9, 32'h0000_0001, 16'd0));
    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'd655));
    add_row(mk(KIND_TICK, 4'd0, 32'd0, 16'd655));

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req);
      if (dir_rows[i].typed) begin
        base = pending_results.size() - NCH;
        pending_results[base].current_out = dir_rows[i].ch0_value;
        pending_results[base + NCH - 1].all_settled = dir_rows[i].all_still;
      end
      pause_sender();
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(CFG_SMOOTH_TIME, 32'd66);
          write_reg(CFG_MAX_SPEED, 32'd0);
          write_reg(CFG_SETTLE_LIMIT, 32'd0);
        end
        1: begin
          write_reg(CFG_SMOOTH_TIME, 32'd65535);
          write_reg(CFG_MAX_SPEED, 32'h7FFF_FFFF);
          write_reg(CFG_SETTLE_LIMIT, 32'd65535);
        end
        2: begin
          write_reg(CFG_SMOOTH_TIME, 32'd30);
          write_reg(CFG_MAX_SPEED, 32'd327680);
          write_reg(CFG_SETTLE_LIMIT, 32'd66);
        end
        3: begin
          write_reg(CFG_SMOOTH_TIME, $urandom);
          write_reg(CFG_MAX_SPEED, $urandom);
          write_reg(CFG_SETTLE_LIMIT, $urandom_range(0, 2000));
        end
        4: begin
          write_reg(CFG_SMOOTH_TIME, 32'd0);
          write_reg(CFG_MAX_SPEED, 32'h7FFF_FFFE);
          write_reg(CFG_SETTLE_LIMIT, 32'd1000);
        end
        default: begin
          write_reg(CFG_SMOOTH_TIME, 32'd6554);
          write_reg(CFG_MAX_SPEED, 32'h7FFF_FFFF);
          write_reg(CFG_SETTLE_LIMIT, 32'd66);
        end
      endcase
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 50; n++) begin
        if (ph == 5 && n >= 10) calm = 1'b1;
        send_request(random_request());
        if (ph != 1 || n >= 8) pause_sender();
      end
    end

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
